@@ rtl/text_console_writer_core_macros.svh @@
// Assertion macros used by the checker file of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tcw_pkg.sv @@
// Shared constants and codes of the text console writer.
package tcw_pkg;

    localparam int MODE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 4;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] FG_RESET     = 4'd15;

endpackage

@@ rtl/tcw_ram.sv @@
// Character cell store: one write port and one read port with registered read data.
module tcw_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/text_console_writer_core.sv @@
// Top level of the text console writer: cursor, sequencer and cell store.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+------------------------------------------
//  request   | start high while busy low | i_mode, i_char_code, i_cell_index
//  result    | o_valid, one cycle        | o_cursor_col, o_cursor_row, o_scrolled,
//            |                           | o_cell_value
//  config    | i_cfg_we                  | i_cfg_wdata (foreground color)
//
// A put or newline goes through S_WRITE and a read or unused-mode request through S_READ
// before its result is strobed; read data comes from the registered read port.
// A clear walks every cell through the single write port.
// A scroll (a put off the last row) copies COLUMNS*(ROWS-1) cells at one per cycle, then
// blanks the last row before the result of the put is strobed.
// After reset the store is blanked in one pass over all cells with busy high.
// The result receiver cannot stall; busy is low again in the strobe cycle.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::MODE_W-1:0]  i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0] i_cell_index,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0] i_cfg_wdata,
    output logic                        o_valid,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic                        o_scrolled,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_value
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_A   = AW'(COPY_COUNT);
    localparam logic [AW-1:0] LAST_A   = AW'(CELL_COUNT - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_SCROLL,
        S_FILL
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_col;
    logic [RW-1:0]                 r_row;
    logic [tcw_pkg::COLOR_W-1:0]   r_fg;
    logic [tcw_pkg::COLOR_W-1:0]   r_fill_color;
    logic [tcw_pkg::CHAR_W-1:0]    r_code;
    logic                          r_nl;
    logic                          r_rd_ok;
    logic                          r_init;
    logic                          r_scr;
    logic [AW-1:0]                 r_addr;
    logic                          r_cp_valid;
    logic [AW-1:0]                 r_cp_addr;
    logic                          r_valid;
    logic                          r_scrolled;
    logic [tcw_pkg::CELL_W-1:0]    r_value;

    logic                          accept;
    logic                          idx_in_range;
    logic                          scroll_rd;
    logic [AW-1:0]                 put_addr;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign idx_in_range = (32'(i_cell_index) < 32'(CELL_COUNT));
    assign scroll_rd    = (r_state == S_SCROLL) && (r_addr < COPY_A);
    assign put_addr     = AW'(r_row) * COLS_A + AW'(r_col);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {4'b0000, r_fill_color, tcw_pkg::BLANK_CODE};
        ram_re    = 1'b0;
        ram_raddr = AW'(i_cell_index);
        case (r_state)
            S_IDLE: begin
                ram_re = accept && (i_mode == tcw_pkg::MODE_READ) && idx_in_range;
            end
            S_WRITE: begin
                ram_we    = !r_nl;
                ram_waddr = put_addr;
                ram_wdata = {4'b0000, r_fg, r_code};
            end
            S_SCROLL: begin
                ram_we    = r_cp_valid;
                ram_waddr = r_cp_addr;
                ram_wdata = ram_rdata;
                ram_re    = scroll_rd;
                ram_raddr = r_addr + COLS_A;
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .DEPTH(CELL_COUNT),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::FG_RESET;
        end else if (i_cfg_we) begin
            r_fg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_col        <= '0;
            r_row        <= '0;
            r_addr       <= '0;
            r_init       <= 1'b1;
            r_fill_color <= tcw_pkg::FG_RESET;
            r_cp_valid   <= 1'b0;
            r_valid      <= 1'b0;
            r_scrolled   <= 1'b0;
            r_scr        <= 1'b0;
            r_value      <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_code <= i_char_code;
                        r_nl   <= (i_char_code == tcw_pkg::NEWLINE_CODE);
                        r_rd_ok <= (i_mode == tcw_pkg::MODE_READ) && idx_in_range;
                        if (i_mode == tcw_pkg::MODE_PUT) begin
                            r_state <= S_WRITE;
                        end else if (i_mode == tcw_pkg::MODE_CLEAR) begin
                            r_col        <= '0;
                            r_row        <= '0;
                            r_addr       <= '0;
                            r_fill_color <= r_fg;
                            r_scr        <= 1'b0;
                            r_state      <= S_FILL;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_WRITE: begin
                    if (r_nl || (r_col == COL_LAST)) begin
                        r_col <= '0;
                        if (r_row == ROW_LAST) begin
                            r_addr       <= '0;
                            r_cp_valid   <= 1'b0;
                            r_fill_color <= r_fg;
                            r_scr        <= 1'b1;
                            r_state      <= S_SCROLL;
                        end else begin
                            r_row      <= r_row + 1'b1;
                            r_valid    <= 1'b1;
                            r_scrolled <= 1'b0;
                            r_value    <= '0;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_col      <= r_col + 1'b1;
                        r_valid    <= 1'b1;
                        r_scrolled <= 1'b0;
                        r_value    <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_valid    <= 1'b1;
                    r_scrolled <= 1'b0;
                    r_value    <= r_rd_ok ? ram_rdata : '0;
                    r_state    <= S_IDLE;
                end
                S_SCROLL: begin
                    if (scroll_rd) begin
                        r_cp_valid <= 1'b1;
                        r_cp_addr  <= r_addr;
                        r_addr     <= r_addr + 1'b1;
                    end else begin
                        r_cp_valid <= 1'b0;
                        r_state    <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_addr == LAST_A) begin
                        r_valid    <= !r_init;
                        r_scrolled <= r_scr;
                        r_value    <= '0;
                        r_init     <= 1'b0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_cursor_col = tcw_pkg::COL_W'(r_col);
    assign o_cursor_row = tcw_pkg::ROW_W'(r_row);
    assign o_scrolled   = r_scrolled;
    assign o_cell_value = r_value;

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checker of the text console writer and its bind to the top level.
`include "text_console_writer_core_macros.svh"

module tcw_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_start,
    input logic                      i_busy,
    input logic                      i_valid,
    input logic                      i_scrolled,
    input logic [tcw_pkg::COL_W-1:0] i_cursor_col
);

    `TCW_ASSERT_NEXT(a_accept_goes_busy, i_start && !i_busy, i_busy, "accept without busy")
    `TCW_ASSERT_NOW(a_result_after_work, i_valid, $past(i_busy), "strobe without work")
    `TCW_ASSERT_NOW(a_result_when_ready, i_valid, !i_busy, "strobe while busy")
    `TCW_ASSERT_NEXT(a_single_strobe, i_valid, !i_valid, "strobe longer than a cycle")
    `TCW_ASSERT_NOW(a_scroll_col0, i_valid && i_scrolled, i_cursor_col == '0, "scroll column")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (start),
    .i_busy      (busy),
    .i_valid     (o_valid),
    .i_scrolled  (o_scrolled),
    .i_cursor_col(o_cursor_col)
);

@@ test/tb_text_console_writer_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_core with its own screen and cursor predictor.
module tb_text_console_writer_core;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [tcw_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

    typedef struct packed {
        logic [tcw_pkg::MODE_W-1:0]  mode;
        logic [tcw_pkg::CHAR_W-1:0]  char_code;
        logic [tcw_pkg::INDEX_W-1:0] cell_index;
    } t_console_req;

    typedef struct packed {
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::ROW_W-1:0]  row;
        logic                       scrolled;
        logic [tcw_pkg::CELL_W-1:0] cell_value;
    } t_console_res;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic [tcw_pkg::MODE_W-1:0]    i_mode       = '0;
    logic [tcw_pkg::CHAR_W-1:0]    i_char_code  = '0;
    logic [tcw_pkg::INDEX_W-1:0]   i_cell_index = '0;
    logic                          i_cfg_we     = 1'b0;
    logic [tcw_pkg::COLOR_W-1:0]   i_cfg_wdata  = '0;
    logic                          busy;
    logic                          o_valid;
    logic [tcw_pkg::COL_W-1:0]     o_cursor_col;
    logic [tcw_pkg::ROW_W-1:0]     o_cursor_row;
    logic                          o_scrolled;
    logic [tcw_pkg::CELL_W-1:0]    o_cell_value;

    t_console_req               pending_reqs[$];
    t_console_res               expected_results[$];
    t_console_req               drive_req;
    logic [tcw_pkg::CELL_W-1:0] screen_image [CELL_COUNT];
    int unsigned                cursor_col_now;
    int unsigned                cursor_row_now;
    logic [tcw_pkg::COLOR_W-1:0] fg_now;
    int                gap_pct = 0;
    int                mismatch_count = 0;
    int                accepted_count = 0;
    int                result_count = 0;
    int                scroll_count = 0;
    int                clear_count = 0;
    int                read_count = 0;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled),
        .o_cell_value (o_cell_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [tcw_pkg::CELL_W-1:0] colored_cell(
        logic [tcw_pkg::CHAR_W-1:0] code
    );
        return {4'b0000, fg_now, code};
    endfunction

    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELL_COUNT; i++) begin
            screen_image[i] = colored_cell(tcw_pkg::BLANK_CODE);
        end
    endfunction

    function automatic t_console_res predict_console(t_console_req r);
        t_console_res e;
        int           pos;
        int           i;
        e = '0;
        case (r.mode)
            tcw_pkg::MODE_PUT: begin
                if (r.char_code == tcw_pkg::NEWLINE_CODE) begin
                    cursor_col_now = 0;
                    cursor_row_now++;
                end else begin
                    pos = cursor_row_now * COLUMNS + cursor_col_now;
                    if (pos < CELL_COUNT) begin
                        screen_image[pos] = colored_cell(r.char_code);
                    end
                    cursor_col_now++;
                    if (cursor_col_now >= COLUMNS) begin
                        cursor_col_now = 0;
                        cursor_row_now++;
                    end
                end
                if (cursor_row_now >= ROWS) begin
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                        screen_image[i] = screen_image[i + COLUMNS];
                    end
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                        screen_image[i] = colored_cell(tcw_pkg::BLANK_CODE);
                    end
                    cursor_row_now = ROWS - 1;
                    cursor_col_now = 0;
                    e.scrolled = 1'b1;
                end
            end
            tcw_pkg::MODE_CLEAR: begin
                blank_screen();
                cursor_col_now = 0;
                cursor_row_now = 0;
            end
            tcw_pkg::MODE_READ: begin
                if (r.cell_index < CELL_COUNT) begin
                    e.cell_value = screen_image[r.cell_index];
                end
            end
            default: begin
            end
        endcase
        e.col = cursor_col_now[tcw_pkg::COL_W-1:0];
        e.row = cursor_row_now[tcw_pkg::ROW_W-1:0];
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
                 $time, what, result_count, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_console(drive_req));
                accepted_count++;
                if (drive_req.mode == tcw_pkg::MODE_CLEAR) begin
                    clear_count++;
                end
                if (drive_req.mode == tcw_pkg::MODE_READ) begin
                    read_count++;
                end
            end
            if (start && busy) begin
            end else if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
                drive_req = pending_reqs.pop_front();
                start        <= 1'b1;
                i_mode       <= drive_req.mode;
                i_char_code  <= drive_req.char_code;
                i_cell_index <= drive_req.cell_index;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_console_res want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_cursor_col !== want.col) begin
                    report_mismatch("cursor_col", 32'(o_cursor_col), 32'(want.col));
                end
                if (o_cursor_row !== want.row) begin
                    report_mismatch("cursor_row", 32'(o_cursor_row), 32'(want.row));
                end
                if (o_scrolled !== want.scrolled) begin
                    report_mismatch("scrolled", 32'(o_scrolled), 32'(want.scrolled));
                end
                if (o_cell_value !== want.cell_value) begin
                    report_mismatch("cell_value", 32'(o_cell_value), 32'(want.cell_value));
                end
                if (want.scrolled) begin
                    scroll_count++;
                end
            end
        end
    end

    task automatic add_req(input logic [tcw_pkg::MODE_W-1:0] mode,
                           input logic [tcw_pkg::CHAR_W-1:0] code,
                           input logic [tcw_pkg::INDEX_W-1:0] idx);
        t_console_req r;
        r.mode       = mode;
        r.char_code  = code;
        r.cell_index = idx;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_until_idle();
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_fg_color(input logic [tcw_pkg::COLOR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        fg_now = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic add_random_reqs(input int count);
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                add_req(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h20)),
                        tcw_pkg::INDEX_W'($urandom));
            end else if (pick < 62) begin
                add_req(tcw_pkg::MODE_PUT, tcw_pkg::CHAR_W'($urandom),
                        tcw_pkg::INDEX_W'($urandom));
            end else if (pick < 70) begin
                add_req(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, tcw_pkg::INDEX_W'($urandom));
            end else if (pick < 82) begin
                add_req(tcw_pkg::MODE_READ, tcw_pkg::CHAR_W'($urandom),
                        tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1,
                                                         CELL_COUNT - 3 * COLUMNS)));
            end else if (pick < 92) begin
                add_req(tcw_pkg::MODE_READ, tcw_pkg::CHAR_W'($urandom),
                        tcw_pkg::INDEX_W'($urandom));
            end else if (pick < 95) begin
                add_req(tcw_pkg::MODE_CLEAR, tcw_pkg::CHAR_W'($urandom),
                        tcw_pkg::INDEX_W'($urandom));
            end else begin
                add_req(MODE_NOP, tcw_pkg::CHAR_W'($urandom), tcw_pkg::INDEX_W'($urandom));
            end
        end
    endtask

    initial begin
        fg_now = tcw_pkg::FG_RESET;
        blank_screen();
        cursor_col_now = 0;
        cursor_row_now = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Directed requests run with the reset color.
        gap_pct = 9;
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd0);
        add_req(tcw_pkg::MODE_READ, 8'hFF, 11'd1999);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd2000);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'h7FF);
        add_req(MODE_NOP, 8'hFF, 11'h7FF);
        add_req(tcw_pkg::MODE_PUT, 8'h41, 11'h7FF);
        add_req(tcw_pkg::MODE_PUT, 8'h00, 11'd0);
        add_req(tcw_pkg::MODE_PUT, 8'hFF, 11'd0);
        add_req(tcw_pkg::MODE_PUT, 8'h80, 11'd0);
        add_req(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
        add_req(tcw_pkg::MODE_PUT, 8'h7F, 11'd0);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd0);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd2);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd3);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd4);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd80);
        add_req(MODE_NOP, tcw_pkg::NEWLINE_CODE, 11'd0);
        add_req(tcw_pkg::MODE_CLEAR, 8'hFF, 11'h7FF);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd0);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd80);
        add_req(tcw_pkg::MODE_PUT, tcw_pkg::BLANK_CODE, 11'd0);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd0);
        wait_until_idle();

        write_fg_color(4'd0);
        add_req(tcw_pkg::MODE_CLEAR, 8'h00, 11'd0);
        add_req(tcw_pkg::MODE_READ, 8'h00, 11'd1999);
        add_random_reqs(260);
        wait_until_idle();

        write_fg_color(4'd15);
        gap_pct = 57;
        add_random_reqs(130);
        wait_until_idle();

        write_fg_color(tcw_pkg::COLOR_W'($urandom_range(14, 1)));
        add_random_reqs(130);
        wait_until_idle();

        write_fg_color(tcw_pkg::COLOR_W'($urandom));
        gap_pct = 0;
        add_random_reqs(260);
        wait_until_idle();

        $display("Run covered %0d requests and %0d results under five color settings.",
                 accepted_count, result_count);
        $display("It included %0d scrolls, %0d screen clears and %0d cell reads.",
                 scroll_count, clear_count, read_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_text_console_writer_core: PASS");
        end else begin
            $display("tb_text_console_writer_core: FAIL");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d results still pending.", expected_results.size());
        $display("tb_text_console_writer_core: FAIL");
        $finish;
    end

endmodule
